// ===== rtl/packet_header_whitelist_filter_defines.svh =====
// assertion macros for the whitelist filter
`ifndef PACKET_HEADER_WHITELIST_FILTER_DEFINES_SVH
`define PACKET_HEADER_WHITELIST_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PHWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PHWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PHWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PHWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/phwf_pkg.sv =====
package phwf_pkg;

    localparam int NUM_TABLES = 7;
    localparam int CNT_W      = 4;
    localparam int ADDR_W     = 5;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int MAC_W      = 48;
    localparam int PROTO_W    = 8;
    localparam int LEN_W      = 16;

    localparam logic [LEN_W-1:0] SHORT_LIMIT = 16'd42;

    typedef enum logic [2:0] {
        TBL_SRC_IP   = 3'd0,
        TBL_DST_IP   = 3'd1,
        TBL_SRC_PORT = 3'd2,
        TBL_DST_PORT = 3'd3,
        TBL_SRC_MAC  = 3'd4,
        TBL_DST_MAC  = 3'd5,
        TBL_PROTO    = 3'd6
    } table_id_t;

    typedef enum logic {
        OP_CLASSIFY = 1'b0,
        OP_WRITE    = 1'b1
    } opcode_t;

endpackage

// ===== rtl/packet_header_whitelist_filter.sv =====
// packet header whitelist filter
// command channel: a word is taken at a rising edge with start high and busy
// low; busy is always low, so one word can be taken every cycle
// opcode 0 classifies a parsed header, opcode 1 loads one table entry
// result channel: done is high for one cycle with accepted and short_frame;
// the receiver cannot stall, so each result is shown exactly once
// a word passes the input register, the compare logic and the result
// register before its result strobe; throughput one word per cycle, set by
// the combinational, parallel compare of every table entry against the header
// a table write lands at the compare stage, so the next word already sees it
// apb port: entry counts at byte address 4*i, one per table, zero disables
// that table; the user must write counts only while no word is in flight,
// which the block leaves unchecked; reset clears the counts and the pipeline
// valid bits; table contents are undefined until written
`include "packet_header_whitelist_filter_defines.svh"

module packet_header_whitelist_filter
    import phwf_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                opcode,
    input  logic [2:0]          table_id,
    input  logic [2:0]          entry_index,
    input  logic [MAC_W-1:0]    entry_value,
    input  logic [LEN_W-1:0]    frame_length,
    input  logic [IP_W-1:0]     src_ip,
    input  logic [IP_W-1:0]     dst_ip,
    input  logic [PORT_W-1:0]   src_port,
    input  logic [PORT_W-1:0]   dst_port,
    input  logic [MAC_W-1:0]    src_mac,
    input  logic [MAC_W-1:0]    dst_mac,
    input  logic [PROTO_W-1:0]  ip_protocol,
    output logic                done,
    output logic                accepted,
    output logic                short_frame,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [CNT_W-1:0]    cnt_reg [NUM_TABLES];
    logic [2:0]          reg_sel;
    logic                cfg_we;

    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [2:0]          s1_tid_reg;
    logic [2:0]          s1_idx_reg;
    logic [MAC_W-1:0]    s1_val_reg;
    logic [LEN_W-1:0]    s1_len_reg;
    logic [IP_W-1:0]     s1_src_ip_reg;
    logic [IP_W-1:0]     s1_dst_ip_reg;
    logic [PORT_W-1:0]   s1_src_port_reg;
    logic [PORT_W-1:0]   s1_dst_port_reg;
    logic [MAC_W-1:0]    s1_src_mac_reg;
    logic [MAC_W-1:0]    s1_dst_mac_reg;
    logic [PROTO_W-1:0]  s1_proto_reg;

    logic [IP_W-1:0]     src_ip_tbl   [TABLE_DEPTH];
    logic [IP_W-1:0]     dst_ip_tbl   [TABLE_DEPTH];
    logic [PORT_W-1:0]   src_port_tbl [TABLE_DEPTH];
    logic [PORT_W-1:0]   dst_port_tbl [TABLE_DEPTH];
    logic [MAC_W-1:0]    src_mac_tbl  [TABLE_DEPTH];
    logic [MAC_W-1:0]    dst_mac_tbl  [TABLE_DEPTH];
    logic [PROTO_W-1:0]  proto_tbl    [TABLE_DEPTH];

    logic [NUM_TABLES-1:0] hit;
    logic [NUM_TABLES-1:0] pass;
    logic                  is_short;
    logic                  tbl_wr;
    logic                  accepted_next;
    logic                  short_next;

    logic                done_reg;
    logic                accepted_reg;
    logic                short_reg;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // config registers
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                cnt_reg[t] <= '0;
            end
        end
        else if (cfg_we && (int'(reg_sel) < NUM_TABLES))
        begin
            cnt_reg[reg_sel] <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (int'(reg_sel) < NUM_TABLES)
        begin
            prdata = {{(32-CNT_W){1'b0}}, cnt_reg[reg_sel]};
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_op_reg       <= opcode;
            s1_tid_reg      <= table_id;
            s1_idx_reg      <= entry_index;
            s1_val_reg      <= entry_value;
            s1_len_reg      <= frame_length;
            s1_src_ip_reg   <= src_ip;
            s1_dst_ip_reg   <= dst_ip;
            s1_src_port_reg <= src_port;
            s1_dst_port_reg <= dst_port;
            s1_src_mac_reg  <= src_mac;
            s1_dst_mac_reg  <= dst_mac;
            s1_proto_reg    <= ip_protocol;
        end
    end

    // table writes
    assign tbl_wr = s1_valid_reg && (s1_op_reg == OP_WRITE);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tbl_wr && (int'(s1_idx_reg) == i))
            begin
                case (s1_tid_reg)
                    TBL_SRC_IP:   src_ip_tbl[i]   <= s1_val_reg[IP_W-1:0];
                    TBL_DST_IP:   dst_ip_tbl[i]   <= s1_val_reg[IP_W-1:0];
                    TBL_SRC_PORT: src_port_tbl[i] <= s1_val_reg[PORT_W-1:0];
                    TBL_DST_PORT: dst_port_tbl[i] <= s1_val_reg[PORT_W-1:0];
                    TBL_SRC_MAC:  src_mac_tbl[i]  <= s1_val_reg;
                    TBL_DST_MAC:  dst_mac_tbl[i]  <= s1_val_reg;
                    TBL_PROTO:    proto_tbl[i]    <= s1_val_reg[PROTO_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // parallel compare, entries past the count are ignored
    always_comb
    begin
        hit = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit[TBL_SRC_IP] = hit[TBL_SRC_IP] ||
                ((i < int'(cnt_reg[TBL_SRC_IP])) && (src_ip_tbl[i] == s1_src_ip_reg));
            hit[TBL_DST_IP] = hit[TBL_DST_IP] ||
                ((i < int'(cnt_reg[TBL_DST_IP])) && (dst_ip_tbl[i] == s1_dst_ip_reg));
            hit[TBL_SRC_PORT] = hit[TBL_SRC_PORT] ||
                ((i < int'(cnt_reg[TBL_SRC_PORT])) && (src_port_tbl[i] == s1_src_port_reg));
            hit[TBL_DST_PORT] = hit[TBL_DST_PORT] ||
                ((i < int'(cnt_reg[TBL_DST_PORT])) && (dst_port_tbl[i] == s1_dst_port_reg));
            hit[TBL_SRC_MAC] = hit[TBL_SRC_MAC] ||
                ((i < int'(cnt_reg[TBL_SRC_MAC])) && (src_mac_tbl[i] == s1_src_mac_reg));
            hit[TBL_DST_MAC] = hit[TBL_DST_MAC] ||
                ((i < int'(cnt_reg[TBL_DST_MAC])) && (dst_mac_tbl[i] == s1_dst_mac_reg));
            hit[TBL_PROTO] = hit[TBL_PROTO] ||
                ((i < int'(cnt_reg[TBL_PROTO])) && (proto_tbl[i] == s1_proto_reg));
        end
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            pass[t] = (cnt_reg[t] == '0) || hit[t];
        end
    end

    assign is_short      = (s1_len_reg <= SHORT_LIMIT);
    assign short_next    = (s1_op_reg == OP_CLASSIFY) && is_short;
    assign accepted_next = (s1_op_reg == OP_CLASSIFY) && !is_short && (&pass);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            accepted_reg <= accepted_next;
            short_reg    <= short_next;
        end
    end

    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign short_frame = short_reg;

    `PHWF_ASSERT_NXT(a_result_follows, clk, rst_n, s1_valid_reg, done)
    `PHWF_ASSERT_NXT(a_no_spurious_result, clk, rst_n, !s1_valid_reg, !done)
    `PHWF_ASSERT_IMP(a_short_rejected, clk, rst_n, done, !(accepted && short_frame))
    `PHWF_ASSERT_NXT(a_write_not_accepted, clk, rst_n, tbl_wr, !accepted && !short_frame)
    `PHWF_ASSERT_NXT(a_short_flagged, clk, rst_n,
        s1_valid_reg && (s1_op_reg == OP_CLASSIFY) && is_short, short_frame)

endmodule

// ===== bench/phwf_checker.sv =====
`timescale 1ns / 100ps

module phwf_checker
    import phwf_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                opcode,
    input  logic [2:0]          table_id,
    input  logic [2:0]          entry_index,
    input  logic [MAC_W-1:0]    entry_value,
    input  logic [LEN_W-1:0]    frame_length,
    input  logic [IP_W-1:0]     src_ip,
    input  logic [IP_W-1:0]     dst_ip,
    input  logic [PORT_W-1:0]   src_port,
    input  logic [PORT_W-1:0]   dst_port,
    input  logic [MAC_W-1:0]    src_mac,
    input  logic [MAC_W-1:0]    dst_mac,
    input  logic [PROTO_W-1:0]  ip_protocol,
    input  logic                done,
    input  logic                accepted,
    input  logic                short_frame,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  pending
);

    typedef struct packed {
        logic accepted;
        logic short_frame;
    } verdict_t;

    logic [MAC_W-1:0]  whitelist [NUM_TABLES][TABLE_DEPTH];
    logic [CNT_W-1:0]  entries_in_use [NUM_TABLES];
    logic [ADDR_W-3:0] reg_idx;
    verdict_t          verdict_q [$];
    verdict_t          want;
    int                mismatch_count = 0;

    assign mismatches = mismatch_count;
    assign reg_idx    = paddr[ADDR_W-1:2];

    function automatic logic [MAC_W-1:0] width_mask(input table_id_t t);
        logic [MAC_W-1:0] m;
        m = '0;
        case (t)
            TBL_SRC_IP, TBL_DST_IP:     m[IP_W-1:0] = '1;
            TBL_SRC_PORT, TBL_DST_PORT: m[PORT_W-1:0] = '1;
            TBL_SRC_MAC, TBL_DST_MAC:   m[MAC_W-1:0] = '1;
            TBL_PROTO:                  m[PROTO_W-1:0] = '1;
            default:                    m = '0;
        endcase
        return m;
    endfunction

    function automatic verdict_t classify_header();
        verdict_t         v;
        logic [MAC_W-1:0] field [NUM_TABLES];
        logic [MAC_W-1:0] key;
        int               n;
        logic             hit;
        v = '0;
        field[TBL_SRC_IP]   = MAC_W'(src_ip);
        field[TBL_DST_IP]   = MAC_W'(dst_ip);
        field[TBL_SRC_PORT] = MAC_W'(src_port);
        field[TBL_DST_PORT] = MAC_W'(dst_port);
        field[TBL_SRC_MAC]  = src_mac;
        field[TBL_DST_MAC]  = dst_mac;
        field[TBL_PROTO]    = MAC_W'(ip_protocol);
        if (opcode == OP_WRITE)
            return v;
        if (frame_length <= SHORT_LIMIT)
        begin
            v.short_frame = 1'b1;
            return v;
        end
        v.accepted = 1'b1;
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            // counts above the table depth saturate
            n = (entries_in_use[t] > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use[t]);
            if (n != 0)
            begin
                key = field[t] & width_mask(table_id_t'(t));
                hit = 1'b0;
                for (int i = 0; i < n; i++)
                    if (whitelist[t][i] == key)
                        hit = 1'b1;
                if (!hit)
                    v.accepted = 1'b0;
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t: %s is %0h, should be %0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TABLES; t++)
                entries_in_use[t] = '0;
            verdict_q.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result with no word in flight, done", 64'(done), 64'd0);
                else
                begin
                    want = verdict_q.pop_front();
                    if (accepted !== want.accepted)
                        report_mismatch("accepted", 64'(accepted), 64'(want.accepted));
                    if (short_frame !== want.short_frame)
                        report_mismatch("short_frame", 64'(short_frame), 64'(want.short_frame));
                end
            end
            if (psel && penable && pready && reg_idx < NUM_TABLES)
            begin
                if (pwrite)
                    entries_in_use[reg_idx] = pwdata[CNT_W-1:0];
                else if (prdata !== 32'(entries_in_use[reg_idx]))
                    report_mismatch("prdata", 64'(prdata), 64'(entries_in_use[reg_idx]));
            end
            if (start && !busy)
            begin
                verdict_q.push_back(classify_header());
                if (opcode == OP_WRITE && table_id < NUM_TABLES && entry_index < TABLE_DEPTH)
                    whitelist[table_id][entry_index] =
                        entry_value & width_mask(table_id_t'(table_id));
            end
            pending <= verdict_q.size();
        end
    end

endmodule

// ===== bench/tb_packet_header_whitelist_filter.sv =====
`timescale 1ns / 100ps

module tb_packet_header_whitelist_filter;
    import phwf_pkg::*;

    localparam int TABLE_DEPTH     = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 98;

    typedef struct packed {
        logic                op;
        logic [2:0]          tid;
        logic [2:0]          idx;
        logic [MAC_W-1:0]    val;
        logic [LEN_W-1:0]    flen;
        logic [IP_W-1:0]     sip;
        logic [IP_W-1:0]     dip;
        logic [PORT_W-1:0]   sport;
        logic [PORT_W-1:0]   dport;
        logic [MAC_W-1:0]    smac;
        logic [MAC_W-1:0]    dmac;
        logic [PROTO_W-1:0]  proto;
    } frame_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                opcode = OP_CLASSIFY;
    logic [2:0]          table_id = '0;
    logic [2:0]          entry_index = '0;
    logic [MAC_W-1:0]    entry_value = '0;
    logic [LEN_W-1:0]    frame_length = '0;
    logic [IP_W-1:0]     src_ip = '0;
    logic [IP_W-1:0]     dst_ip = '0;
    logic [PORT_W-1:0]   src_port = '0;
    logic [PORT_W-1:0]   dst_port = '0;
    logic [MAC_W-1:0]    src_mac = '0;
    logic [MAC_W-1:0]    dst_mac = '0;
    logic [PROTO_W-1:0]  ip_protocol = '0;
    logic                done;
    logic                accepted;
    logic                short_frame;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  mismatches;
    int                  pending;

    logic [MAC_W-1:0]    loaded [NUM_TABLES][TABLE_DEPTH];
    logic [CNT_W-1:0]    active_count [NUM_TABLES];
    int                  idle_pct = 0;
    int                  quiet_cycles = 0;

    packet_header_whitelist_filter #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (.*);

    phwf_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue_word(input frame_word_t w);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        opcode       <= w.op;
        table_id     <= w.tid;
        entry_index  <= w.idx;
        entry_value  <= w.val;
        frame_length <= w.flen;
        src_ip       <= w.sip;
        dst_ip       <= w.dip;
        src_port     <= w.sport;
        dst_port     <= w.dport;
        src_mac      <= w.smac;
        dst_mac      <= w.dmac;
        ip_protocol  <= w.proto;
        start        <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (w.op == OP_WRITE && w.tid < NUM_TABLES)
            loaded[w.tid][w.idx] = w.val;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input int index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(4 * index);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_count(input int t, input logic [CNT_W-1:0] value);
        logic [31:0] data;
        data = $urandom;
        data[CNT_W-1:0] = value;
        apb_access(1'b1, t, data);
        if (t < NUM_TABLES)
        begin
            active_count[t] = value;
            apb_access(1'b0, t, 32'd0);
        end
    endtask

    task automatic set_all_counts(input logic [CNT_W-1:0] value);
        drain_results();
        for (int t = 0; t < NUM_TABLES; t++)
            write_count(t, value);
    endtask

    function automatic logic [CNT_W-1:0] phase_count(input int p, input int t);
        case (p)
            1:       return CNT_W'(TABLE_DEPTH);
            3:       return '1;
            4:       return CNT_W'($urandom_range(TABLE_DEPTH));
            5:       return (t == int'(TBL_SRC_PORT) || t == int'(TBL_PROTO)) ?
                            CNT_W'(2) : CNT_W'(0);
            7:       return CNT_W'(1);
            default: return CNT_W'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [MAC_W-1:0] header_field(input table_id_t t, input bit want_hit);
        int n;
        n = (active_count[t] > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count[t]);
        if (want_hit && n > 0)
            return loaded[t][$urandom_range(n - 1)];
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic bit roll_hit(input int mode);
        return mode < 50 || (mode < 85 && $urandom_range(3) != 0);
    endfunction

    function automatic frame_word_t uniform_header(input logic [LEN_W-1:0] flen,
                                                   input logic [MAC_W-1:0] fill);
        frame_word_t w;
        w       = '0;
        w.op    = OP_CLASSIFY;
        w.flen  = flen;
        w.sip   = fill[IP_W-1:0];
        w.dip   = fill[IP_W-1:0];
        w.sport = fill[PORT_W-1:0];
        w.dport = fill[PORT_W-1:0];
        w.smac  = fill;
        w.dmac  = fill;
        w.proto = fill[PROTO_W-1:0];
        return w;
    endfunction

    function automatic frame_word_t random_word();
        frame_word_t w;
        int          kind;
        int          mode;
        w.op  = OP_CLASSIFY;
        w.tid = 3'($urandom);
        w.idx = 3'($urandom);
        w.val = MAC_W'({$urandom, $urandom});
        if ($urandom_range(99) < 10)
        begin
            w.op = OP_WRITE;
            w.tid = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(NUM_TABLES - 1));
        end
        kind = $urandom_range(99);
        if (kind < 8)
            w.flen = LEN_W'($urandom_range(SHORT_LIMIT));
        else if (kind < 16)
            w.flen = LEN_W'($urandom);
        else
            w.flen = LEN_W'($urandom_range(1518, SHORT_LIMIT + 1));
        mode    = $urandom_range(99);
        w.sip   = IP_W'(header_field(TBL_SRC_IP, roll_hit(mode)));
        w.dip   = IP_W'(header_field(TBL_DST_IP, roll_hit(mode)));
        w.sport = PORT_W'(header_field(TBL_SRC_PORT, roll_hit(mode)));
        w.dport = PORT_W'(header_field(TBL_DST_PORT, roll_hit(mode)));
        w.smac  = header_field(TBL_SRC_MAC, roll_hit(mode));
        w.dmac  = header_field(TBL_DST_MAC, roll_hit(mode));
        w.proto = PROTO_W'(header_field(TBL_PROTO, roll_hit(mode)));
        return w;
    endfunction

    initial
    begin
        frame_word_t w;
        for (int t = 0; t < NUM_TABLES; t++)
            active_count[t] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every entry first, entry 0 all zeros and the last one all ones
        for (int t = 0; t < NUM_TABLES; t++)
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                w     = random_word();
                w.op  = OP_WRITE;
                w.tid = 3'(t);
                w.idx = 3'(i);
                w.val = (i == 0) ? '0 : (i == TABLE_DEPTH - 1) ? '1 : w.val;
                issue_word(w);
            end

        // all checks disabled
        issue_word(uniform_header(16'd0, '0));
        issue_word(uniform_header(LEN_W'(SHORT_LIMIT), '1));
        issue_word(uniform_header(LEN_W'(SHORT_LIMIT) + 16'd1, '1));
        issue_word(uniform_header('1, '0));
        w     = uniform_header('1, '1);
        w.op  = OP_WRITE;
        w.tid = 3'd7;
        issue_word(w);
        // entry value wider than the protocol table
        w.tid = TBL_PROTO;
        w.idx = 3'(TABLE_DEPTH - 1);
        w.val = '1;
        issue_word(w);

        // one entry per table, entry 0 holds zero
        set_all_counts(CNT_W'(1));
        write_count(7, '1);
        issue_word(uniform_header(LEN_W'(SHORT_LIMIT) + 16'd1, '0));
        w     = uniform_header(LEN_W'(SHORT_LIMIT) + 16'd1, '0);
        w.sip = 32'd1;
        issue_word(w);
        w       = uniform_header(16'd100, '0);
        w.proto = 8'h80;
        issue_word(w);
        issue_word(uniform_header(LEN_W'(SHORT_LIMIT), '0));

        // full depth, then counts above the depth
        set_all_counts(CNT_W'(TABLE_DEPTH));
        issue_word(uniform_header('1, '1));
        w      = uniform_header(16'd64, '1);
        w.dmac = 48'h7fff_ffff_ffff;
        issue_word(w);
        set_all_counts('1);
        issue_word(uniform_header(16'd1500, '1));
        issue_word(uniform_header(16'd1500, '0));
        w       = uniform_header(16'd1500, '0);
        w.dport = 16'h8000;
        issue_word(w);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            for (int t = 0; t < NUM_TABLES; t++)
                write_count(t, phase_count(p, t));
            case (p % 4)
                1:       idle_pct = 77;
                3:       idle_pct = 25;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (p == 2 && n == WORDS_PER_PHASE / 2)
                    drain_results();
                issue_word(random_word());
            end
        end

        idle_pct = 0;
        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/phwf_pkg.sv
rtl/packet_header_whitelist_filter.sv
bench/phwf_checker.sv
bench/tb_packet_header_whitelist_filter.sv
